// File: design/flash_circular_log_addresser_macros.svh
// Assertion macros for the flash circular log addresser.
// Used by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef FLASH_CIRCULAR_LOG_ADDRESSER_MACROS_SVH
`define FLASH_CIRCULAR_LOG_ADDRESSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define FLCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define FLCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define FLCL_ASSERT_IMP(lbl, ante, cons)
`define FLCL_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: design/flcl_pkg.sv
// Package for the flash circular log addresser: field widths, codes,
// register map and the configuration struct. No dependencies.
`timescale 1ns / 1ps

package flcl_pkg;

  // Default width of the write pointer.
  localparam int ADDR_WIDTH_DEF = 24;

  // Field and register widths.
  localparam int OP_W    = 3;
  localparam int NUM_W   = 24;
  localparam int CMD_W   = 3;
  localparam int ST_W    = 2;
  localparam int OUTA_W  = 24;
  localparam int CNT_W   = 25;
  localparam int EB_W    = 13;
  localparam int SB_W    = 17;
  localparam int FA_W    = 24;
  localparam int RB_W    = 25;
  localparam int ME_W    = 25;
  localparam int EPS_W   = 17;
  localparam int PROD_W  = CNT_W + EB_W;
  localparam int END_W   = RB_W + 1;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Operations.
  localparam logic [OP_W-1:0] OP_STORE     = 3'd0;
  localparam logic [OP_W-1:0] OP_READ      = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_NEXT = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET_CUR = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

  // Flash commands.
  localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ERASE_ALL = 3'd4;

  // Result status.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_ENTRY_BYTES  = 3'd0;
  localparam logic [2:0] REG_SECTOR_BYTES = 3'd1;
  localparam logic [2:0] REG_FIRST_ADDR   = 3'd2;
  localparam logic [2:0] REG_REGION_BYTES = 3'd3;
  localparam logic [2:0] REG_MAX_ENTRIES  = 3'd4;
  localparam logic [2:0] REG_ENT_PER_SEC  = 3'd5;

  // Register reset values.
  localparam logic [EB_W-1:0]  RST_ENTRY_BYTES  = 13'd8;
  localparam logic [SB_W-1:0]  RST_SECTOR_BYTES = 17'd4096;
  localparam logic [FA_W-1:0]  RST_FIRST_ADDR   = 24'd0;
  localparam logic [RB_W-1:0]  RST_REGION_BYTES = 25'd65536;
  localparam logic [ME_W-1:0]  RST_MAX_ENTRIES  = 25'd8192;
  localparam logic [EPS_W-1:0] RST_ENT_PER_SEC  = 17'd512;

  // Configuration handed from the register file to the sequencer.
  typedef struct packed {
    logic [EB_W-1:0]  entry_bytes;
    logic [SB_W-1:0]  sector_bytes;
    logic [FA_W-1:0]  first_address;
    logic [RB_W-1:0]  region_bytes;
    logic [ME_W-1:0]  max_entries;
    logic [EPS_W-1:0] entries_per_sector;
  } cfg_t;

  // Request to the shared iterative unit.
  typedef struct packed {
    logic start;
    logic mode_mul;
  } iter_req_t;

endpackage

// File: design/flash_circular_log_addresser.sv
// Top level of the flash circular log addresser: sequencer, log state and
// output register. Depends on flcl_pkg, flcl_cfg, flcl_iter and the macro header.
//
// Usage:
// - Input channel (in_valid, in_stall, in_operation, in_entry_number) takes one
//   log request per transfer. in_stall is high while a request is in work.
// - Result channel (out_valid, out_stall, out_*) carries one or two results per
//   request; out_last marks the final one. A store on a sector boundary gives an
//   erase result followed by a write result.
// - Write configuration over the APB-style port only while the block is idle; the block does not enforce this.
// - A store runs ADDR_WIDTH modulo steps on the shared unit before its first result;
//   a read that hits runs ADDR_WIDTH modulo steps plus 13 multiply steps on the shared
//   unit; other operations skip the shared unit. Requests are taken one at a time.
// - The next request is taken as soon as its last result sits in the output
//   register, even if the receiver stalls it there.
// - A stalled result holds in the output register; a second result waits in
//   the sequencer until the register frees.
// - Reset clears the write pointer, the entry count and the read cursor, and
//   loads the register reset values.
`timescale 1ns / 1ps
`include "flash_circular_log_addresser_macros.svh"

module flash_circular_log_addresser #(
  parameter int ADDR_WIDTH = flcl_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [flcl_pkg::OP_W-1:0]     in_operation,
  input  logic [flcl_pkg::NUM_W-1:0]    in_entry_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [flcl_pkg::CMD_W-1:0]    out_command,
  output logic [flcl_pkg::ST_W-1:0]     out_status,
  output logic [flcl_pkg::OUTA_W-1:0]   out_flash_address,
  output logic [flcl_pkg::CNT_W-1:0]    out_entry_count,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flcl_pkg::CFG_AW-1:0]   paddr,
  input  logic [flcl_pkg::CFG_DW-1:0]   pwdata,
  output logic [flcl_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int AW    = ADDR_WIDTH;
  localparam int CW    = flcl_pkg::CNT_W;
  localparam int SBW   = flcl_pkg::SB_W;
  localparam int EW    = flcl_pkg::END_W;
  localparam int OW    = ((AW > SBW) ? AW : SBW) + 1;
  localparam int LW    = ((flcl_pkg::PROD_W > OW) ? flcl_pkg::PROD_W : OW) + 1;
  localparam int SWD   = ((AW + 1) > EW) ? (AW + 1) : EW;
  localparam int OAW   = flcl_pkg::OUTA_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_MOD    = 4'd2;
  localparam logic [3:0] S_ST1    = 4'd3;
  localparam logic [3:0] S_ST2    = 4'd4;
  localparam logic [3:0] S_RDOLD  = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_RDADD  = 4'd7;
  localparam logic [3:0] S_RDWRAP = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  flcl_pkg::cfg_t       cfg;
  flcl_pkg::iter_req_t  iter_req;
  logic                 iter_done;
  logic [SBW-1:0]       iter_rem;
  logic [flcl_pkg::PROD_W-1:0] iter_prod;

  logic [3:0]                     state_r, state_nxt;
  logic [flcl_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [flcl_pkg::NUM_W-1:0]     num_r, num_nxt;
  logic [AW-1:0]                  wp_r, wp_nxt;
  logic [CW-1:0]                  vc_r, vc_nxt;
  logic [flcl_pkg::NUM_W-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]                  diff_r, diff_nxt;
  logic [LW-1:0]                  oldest_r, oldest_nxt;
  logic [LW-1:0]                  addr_r, addr_nxt;
  logic [flcl_pkg::CMD_W-1:0]     res_cmd_r, res_cmd_nxt;
  logic [flcl_pkg::ST_W-1:0]      res_st_r, res_st_nxt;
  logic [OAW-1:0]                 res_addr_r, res_addr_nxt;
  logic                           res_last_r, res_last_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [flcl_pkg::CMD_W-1:0]     out_cmd_r, out_cmd_nxt;
  logic [flcl_pkg::ST_W-1:0]      out_st_r, out_st_nxt;
  logic [OAW-1:0]                 out_addr_r, out_addr_nxt;
  logic [CW-1:0]                  out_cnt_r, out_cnt_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [SBW-1:0]                 sec_eff;
  logic [EW-1:0]                  region_end;
  logic                           slot_free;
  logic [flcl_pkg::NUM_W-1:0]     rd_num;
  logic [flcl_pkg::NUM_W-1:0]     cur_inc;
  logic                           erase;
  logic [SWD-1:0]                 wp_sum;
  logic                           wrap_case;
  logic [OW-1:0]                  oldest_w;
  logic [LW-1:0]                  addr_fix;

  // Register file.
  flcl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared modulo / multiply unit.
  flcl_iter #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (iter_req),
    .dividend (wp_r),
    .divisor  (sec_eff),
    .mcand    (diff_r),
    .mplier   (cfg.entry_bytes),
    .done     (iter_done),
    .rem      (iter_rem),
    .prod     (iter_prod)
  );

  // Derived configuration values; a zero sector size acts as one byte.
  assign sec_eff    = (cfg.sector_bytes == '0) ? SBW'(1) : cfg.sector_bytes;
  assign region_end = EW'(cfg.first_address) + EW'(cfg.region_bytes);
  assign slot_free  = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != S_IDLE);

  // Per-state datapath terms.
  assign rd_num    = (op_r == flcl_pkg::OP_READ) ? num_r : cur_r;
  assign cur_inc   = cur_r + flcl_pkg::NUM_W'(1);
  assign erase     = (iter_rem == '0);
  assign wp_sum    = SWD'(wp_r) + SWD'(cfg.entry_bytes);
  assign wrap_case = ((CW+1)'(vc_r) + (CW+1)'(cfg.entries_per_sector))
                     > (CW+1)'(cfg.max_entries);
  assign oldest_w  = (iter_rem == '0) ? OW'(wp_r)
                     : (OW'(wp_r) - OW'(iter_rem) + OW'(sec_eff));
  assign addr_fix  = (addr_r >= LW'(region_end)) ? (addr_r - LW'(cfg.region_bytes)) : addr_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    num_nxt       = num_r;
    wp_nxt        = wp_r;
    vc_nxt        = vc_r;
    cur_nxt       = cur_r;
    diff_nxt      = diff_r;
    oldest_nxt    = oldest_r;
    addr_nxt      = addr_r;
    res_cmd_nxt   = res_cmd_r;
    res_st_nxt    = res_st_r;
    res_addr_nxt  = res_addr_r;
    res_last_nxt  = res_last_r;
    iter_req      = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_cmd_nxt   = out_cmd_r;
    out_st_nxt    = out_st_r;
    out_addr_nxt  = out_addr_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          num_nxt   = in_entry_number;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_cmd_nxt  = flcl_pkg::CMD_NONE;
        res_st_nxt   = flcl_pkg::ST_OK;
        res_addr_nxt = '0;
        res_last_nxt = 1'b1;
        state_nxt    = S_EMIT;
        case (op_r)
          flcl_pkg::OP_STORE: begin
            iter_req.start = 1'b1;
            state_nxt      = S_MOD;
          end
          flcl_pkg::OP_READ, flcl_pkg::OP_READ_NEXT: begin
            if (op_r == flcl_pkg::OP_READ_NEXT) begin
              cur_nxt = ((CW)'(cur_inc) >= vc_r) ? '0 : cur_inc;
            end
            if (CW'(rd_num) >= vc_r) begin
              res_st_nxt = flcl_pkg::ST_MISSING;
            end else begin
              diff_nxt       = vc_r - CW'(rd_num) - CW'(1);
              iter_req.start = 1'b1;
              state_nxt      = S_MOD;
            end
          end
          flcl_pkg::OP_RESET_CUR: begin
            cur_nxt = '0;
          end
          flcl_pkg::OP_CLEAR: begin
            wp_nxt      = AW'(cfg.first_address);
            vc_nxt      = '0;
            res_cmd_nxt = flcl_pkg::CMD_ERASE_ALL;
          end
          default: ;
        endcase
      end

      S_MOD: begin
        if (iter_done) begin
          state_nxt = (op_r == flcl_pkg::OP_STORE) ? S_ST1 : S_RDOLD;
        end
      end

      // Store: sector erase decision and the full-log drop.
      S_ST1: begin
        if (erase && (vc_r >= cfg.max_entries)) begin
          vc_nxt = (vc_r >= CW'(cfg.entries_per_sector))
                   ? (vc_r - CW'(cfg.entries_per_sector)) : '0;
        end
        res_cmd_nxt  = erase ? flcl_pkg::CMD_ERASE : flcl_pkg::CMD_WRITE;
        res_st_nxt   = flcl_pkg::ST_OK;
        res_addr_nxt = OAW'(wp_r);
        res_last_nxt = !erase;
        state_nxt    = S_ST2;
      end

      // Store: count the entry and advance the pointer with wrap.
      S_ST2: begin
        if (vc_r < flcl_pkg::CNT_MAX) begin
          vc_nxt = vc_r + CW'(1);
        end
        wp_nxt    = (wp_sum >= SWD'(region_end)) ? AW'(cfg.first_address) : AW'(wp_sum);
        state_nxt = S_EMIT;
      end

      // Read: locate the oldest entry, then start the offset multiply.
      S_RDOLD: begin
        if (wrap_case && (LW'(oldest_w) != LW'(region_end))) begin
          oldest_nxt = LW'(oldest_w);
        end else begin
          oldest_nxt = LW'(cfg.first_address);
        end
        iter_req.start    = 1'b1;
        iter_req.mode_mul = 1'b1;
        state_nxt         = S_MUL;
      end

      S_MUL: begin
        if (iter_done) begin
          state_nxt = S_RDADD;
        end
      end

      S_RDADD: begin
        addr_nxt  = LW'(iter_prod) + oldest_r;
        state_nxt = S_RDWRAP;
      end

      // Read: wrap once at the region end and check the range.
      S_RDWRAP: begin
        res_addr_nxt = addr_fix[OAW-1:0];
        res_last_nxt = 1'b1;
        if (addr_fix >= LW'(region_end)) begin
          res_cmd_nxt = flcl_pkg::CMD_NONE;
          res_st_nxt  = flcl_pkg::ST_RANGE;
        end else begin
          res_cmd_nxt = flcl_pkg::CMD_READ;
          res_st_nxt  = flcl_pkg::ST_OK;
        end
        state_nxt = S_EMIT;
      end

      // Hand results to the output register as it frees.
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_cmd_nxt   = res_cmd_r;
          out_st_nxt    = res_st_r;
          out_addr_nxt  = res_addr_r;
          out_cnt_nxt   = vc_r;
          out_last_nxt  = res_last_r;
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            res_cmd_nxt  = flcl_pkg::CMD_WRITE;
            res_last_nxt = 1'b1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and log state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      vc_r        <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      vc_r        <= vc_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    num_r      <= num_nxt;
    diff_r     <= diff_nxt;
    oldest_r   <= oldest_nxt;
    addr_r     <= addr_nxt;
    res_cmd_r  <= res_cmd_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    res_last_r <= res_last_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_command       = out_cmd_r;
  assign out_status        = out_st_r;
  assign out_flash_address = out_addr_r;
  assign out_entry_count   = out_cnt_r;
  assign out_last          = out_last_r;

  // An erase is always followed by its write.
  `FLCL_ASSERT_IMP(a_erase_not_last,
    out_valid_r && (out_cmd_r == flcl_pkg::CMD_ERASE), !out_last_r)
  // Error results carry no flash command.
  `FLCL_ASSERT_IMP(a_err_no_cmd,
    out_valid_r && (out_st_r != flcl_pkg::ST_OK), out_cmd_r == flcl_pkg::CMD_NONE)
  // The shared unit only finishes while the sequencer waits for it.
  `FLCL_ASSERT_IMP(a_iter_done_wait,
    iter_done, (state_r == S_MOD) || (state_r == S_MUL))
  // A write result always reports at least one stored entry.
  `FLCL_ASSERT_IMP(a_write_count,
    out_valid_r && (out_cmd_r == flcl_pkg::CMD_WRITE), out_cnt_r != '0)
  // An accepted request goes straight to decode.
  `FLCL_ASSERT_NXT(a_accept_decode,
    in_valid && (state_r == S_IDLE), state_r == S_DEC)

endmodule

// File: design/flcl_cfg.sv
// APB-style configuration register file for the flash circular log addresser.
// Depends on flcl_pkg for the register map, widths and reset values.
`timescale 1ns / 1ps

module flcl_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [flcl_pkg::CFG_AW-1:0] paddr,
  input  logic [flcl_pkg::CFG_DW-1:0] pwdata,
  output logic [flcl_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output flcl_pkg::cfg_t             cfg
);

  flcl_pkg::cfg_t cfg_r;
  flcl_pkg::cfg_t cfg_nxt;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[flcl_pkg::CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write decode: keep the low register-width bits, ignore unknown indexes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        flcl_pkg::REG_ENTRY_BYTES:
          cfg_nxt.entry_bytes = pwdata[flcl_pkg::EB_W-1:0];
        flcl_pkg::REG_SECTOR_BYTES:
          cfg_nxt.sector_bytes = pwdata[flcl_pkg::SB_W-1:0];
        flcl_pkg::REG_FIRST_ADDR:
          cfg_nxt.first_address = pwdata[flcl_pkg::FA_W-1:0];
        flcl_pkg::REG_REGION_BYTES:
          cfg_nxt.region_bytes = pwdata[flcl_pkg::RB_W-1:0];
        flcl_pkg::REG_MAX_ENTRIES:
          cfg_nxt.max_entries = pwdata[flcl_pkg::ME_W-1:0];
        flcl_pkg::REG_ENT_PER_SEC:
          cfg_nxt.entries_per_sector = pwdata[flcl_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register storage with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_bytes        <= flcl_pkg::RST_ENTRY_BYTES;
      cfg_r.sector_bytes       <= flcl_pkg::RST_SECTOR_BYTES;
      cfg_r.first_address      <= flcl_pkg::RST_FIRST_ADDR;
      cfg_r.region_bytes       <= flcl_pkg::RST_REGION_BYTES;
      cfg_r.max_entries        <= flcl_pkg::RST_MAX_ENTRIES;
      cfg_r.entries_per_sector <= flcl_pkg::RST_ENT_PER_SEC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      flcl_pkg::REG_ENTRY_BYTES:  prdata = flcl_pkg::CFG_DW'(cfg_r.entry_bytes);
      flcl_pkg::REG_SECTOR_BYTES: prdata = flcl_pkg::CFG_DW'(cfg_r.sector_bytes);
      flcl_pkg::REG_FIRST_ADDR:   prdata = flcl_pkg::CFG_DW'(cfg_r.first_address);
      flcl_pkg::REG_REGION_BYTES: prdata = flcl_pkg::CFG_DW'(cfg_r.region_bytes);
      flcl_pkg::REG_MAX_ENTRIES:  prdata = flcl_pkg::CFG_DW'(cfg_r.max_entries);
      flcl_pkg::REG_ENT_PER_SEC:  prdata = flcl_pkg::CFG_DW'(cfg_r.entries_per_sector);
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: design/flcl_iter.sv
// Shared iterative unit: restoring modulo of the write pointer by the sector
// size, and shift-add multiply, both on one adder. Depends on flcl_pkg.
`timescale 1ns / 1ps

module flcl_iter #(
  parameter int ADDR_WIDTH = flcl_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  flcl_pkg::iter_req_t           req,
  input  logic [ADDR_WIDTH-1:0]         dividend,
  input  logic [flcl_pkg::SB_W-1:0]     divisor,
  input  logic [flcl_pkg::CNT_W-1:0]    mcand,
  input  logic [flcl_pkg::EB_W-1:0]     mplier,
  output logic                          done,
  output logic [flcl_pkg::SB_W-1:0]     rem,
  output logic [flcl_pkg::PROD_W-1:0]   prod
);

  localparam int ADD_W = flcl_pkg::CNT_W + 1;
  localparam int CTW   = $clog2(ADDR_WIDTH);
  localparam int EBW   = flcl_pkg::EB_W;
  localparam int SBW   = flcl_pkg::SB_W;
  localparam int PW    = flcl_pkg::PROD_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic                          mode_mul_r, mode_mul_nxt;
  logic [CTW-1:0]                cnt_r, cnt_nxt;
  logic [ADDR_WIDTH-1:0]         dvd_r, dvd_nxt;
  logic [SBW-1:0]                div_r, div_nxt;
  logic [SBW-1:0]                rem_r, rem_nxt;
  logic [flcl_pkg::CNT_W-1:0]    mcand_r, mcand_nxt;
  logic [PW-1:0]                 p_r, p_nxt;
  logic [ADD_W-1:0]              add_x, add_y;
  logic [ADD_W:0]                add_sum;
  logic [CTW-1:0]                last_step;

  // The one adder: subtract for the modulo step, add for the multiply step.
  always_comb begin
    if (mode_mul_r) begin
      add_x = {1'b0, p_r[PW-1:EBW]};
      add_y = p_r[0] ? {1'b0, mcand_r} : '0;
    end else begin
      add_x = {{(ADD_W-SBW-1){1'b0}}, rem_r, dvd_r[ADDR_WIDTH-1]};
      add_y = ~{{(ADD_W-SBW){1'b0}}, div_r};
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + (ADD_W+1)'(!mode_mul_r);
  end

  assign last_step = mode_mul_r ? CTW'(EBW - 1) : CTW'(ADDR_WIDTH - 1);

  // Step sequencing.
  always_comb begin
    busy_nxt     = busy_r;
    done_nxt     = 1'b0;
    mode_mul_nxt = mode_mul_r;
    cnt_nxt      = cnt_r;
    dvd_nxt      = dvd_r;
    div_nxt      = div_r;
    rem_nxt      = rem_r;
    mcand_nxt    = mcand_r;
    p_nxt        = p_r;
    if (req.start) begin
      busy_nxt     = 1'b1;
      mode_mul_nxt = req.mode_mul;
      cnt_nxt      = '0;
      dvd_nxt      = dividend;
      div_nxt      = divisor;
      rem_nxt      = '0;
      mcand_nxt    = mcand;
      p_nxt        = {{(PW-EBW){1'b0}}, mplier};
    end else if (busy_r) begin
      if (mode_mul_r) begin
        p_nxt = {add_sum[ADD_W-1:0], p_r[EBW-1:1]};
      end else begin
        rem_nxt = add_sum[ADD_W] ? add_sum[SBW-1:0] : add_x[SBW-1:0];
        dvd_nxt = {dvd_r[ADDR_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CTW'(1);
      if (cnt_r == last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_mul_r <= mode_mul_nxt;
    cnt_r      <= cnt_nxt;
    dvd_r      <= dvd_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    mcand_r    <= mcand_nxt;
    p_r        <= p_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign prod = p_r;

endmodule
